@@ rtl/csc_spmv_request_address_generator_assert.svh @@
`ifndef CSC_SPMV_REQUEST_ADDRESS_GENERATOR_ASSERT_SVH
`define CSC_SPMV_REQUEST_ADDRESS_GENERATOR_ASSERT_SVH

`ifndef NO_ASSERTIONS

`define CSCAG_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("assertion failed");

`define CSCAG_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed");

`else

`define CSCAG_ASSERT_IMP(lbl, clk, rstn, ante, cons)

`define CSCAG_ASSERT_NXT(lbl, clk, rstn, ante, cons)

`endif

`endif

@@ rtl/cscag_pkg.sv @@
package cscag_pkg;

  localparam int unsigned ADDR_W     = 38;
  localparam int unsigned STRIDE_W   = 36;
  localparam int unsigned DIVIDEND_W = 36;
  localparam int unsigned DIVISOR_W  = 32;
  localparam int unsigned STEP_CNT_W = 6;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] REG_NONZERO = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COLUMNS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ENGINES = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV_START,
    ST_DIV_WAIT,
    ST_MUL,
    ST_ADD,
    ST_OUT
  } state_e;

  typedef enum logic [1:0] {
    STR_COLPTR = 2'd0,
    STR_ROWIDX = 2'd1,
    STR_VALUE  = 2'd2,
    STR_VECTOR = 2'd3
  } stream_e;

  typedef enum logic [2:0] {
    JOB_AVG,
    JOB_S0,
    JOB_S1,
    JOB_S2,
    JOB_S3,
    JOB_TOTAL
  } div_job_e;

  typedef struct packed {
    logic                  start;
    logic [DIVIDEND_W-1:0] dividend;
    logic [DIVISOR_W-1:0]  divisor;
  } div_req_t;

  typedef struct packed {
    logic                  done;
    logic [DIVIDEND_W-1:0] quotient;
  } div_rsp_t;

endpackage

@@ rtl/cscag_div.sv @@
module cscag_div (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  cscag_pkg::div_req_t req_i,
  output cscag_pkg::div_rsp_t rsp_o
);
  import cscag_pkg::*;

  logic                  busy_q, busy_d;
  logic                  done_q, done_d;
  logic [STEP_CNT_W-1:0] cnt_q, cnt_d;
  logic [DIVISOR_W-1:0]  rem_q, rem_d;
  logic [DIVIDEND_W-1:0] quo_q, quo_d;
  logic [DIVISOR_W-1:0]  dvs_q, dvs_d;
  logic [DIVISOR_W:0]    trial;
  logic [DIVISOR_W:0]    diff;
  logic                  fits;

  // restoring divide, one quotient bit per cycle
  always_comb begin
    trial = {rem_q, quo_q[DIVIDEND_W-1]};
    diff  = trial - {1'b0, dvs_q};
    fits  = (trial >= {1'b0, dvs_q});
  end

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    dvs_d  = dvs_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = STEP_CNT_W'(DIVIDEND_W);
      rem_d  = '0;
      quo_d  = req_i.dividend;
      dvs_d  = req_i.divisor;
    end else if (busy_q) begin
      rem_d = fits ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
      quo_d = {quo_q[DIVIDEND_W-2:0], fits};
      cnt_d = cnt_q - STEP_CNT_W'(1);
      if (cnt_q == STEP_CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dvs_q <= dvs_d;
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = quo_q;

endmodule

@@ rtl/csc_spmv_request_address_generator.sv @@
// Channel   | Direction | Handshake                  | Word
// ----------+-----------+----------------------------+-----------------------------------------
// input     | in        | in_valid_i / in_stall_o    | restart_i
// output    | out       | out_valid_o / out_stall_i  | address, stream, iteration, engine, ...
// config    | in        | cfg_we_i                   | cfg_index_i, cfg_wdata_i
//
// Restart word: six 36-step divides on one shared divider.
// Advance word: accepted, then per request the multiply, add and present steps
// plus any output stall; 3 or 4 requests. Done word: accepted, then presented.
// Input stall is high whenever a word is in progress.
// Reset clears control state; sizes read as zero until the first restart.
`include "csc_spmv_request_address_generator_assert.svh"

module csc_spmv_request_address_generator (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [cscag_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [cscag_pkg::CFG_DATA_W-1:0]  cfg_wdata_i,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic                              restart_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [cscag_pkg::ADDR_W-1:0]      address_o,
  output logic [1:0]                        stream_o,
  output logic [28:0]                       iteration_o,
  output logic [7:0]                        engine_o,
  output logic                              last_o,
  output logic                              done_res_o
);
  import cscag_pkg::*;

  state_e state_q, state_d;

  logic [31:0] nz_q;
  logic [31:0] cols_q;
  logic [8:0]  pes_q;

  logic [29:0]         iter_q;
  logic [7:0]          eng_q;
  logic [31:0]         cbc_q;
  logic [31:0]         phase_q;
  logic [31:0]         avg_q;
  logic [29:0]         rtotal_q;
  logic [STRIDE_W-1:0] stride_q [4];
  div_job_e            job_q;

  logic [1:0]        strm_q;
  logic [ADDR_W-1:0] base_q;
  logic [ADDR_W-1:0] prod_q;
  logic [ADDR_W-1:0] off_q;
  logic [ADDR_W-1:0] addr_q;
  logic              last_q;
  logic              done_q;

  logic [31:0]       cols_eff;
  logic [8:0]        pes_eff;
  logic              in_acc;
  logic              out_acc;
  logic              seq_end;
  logic              div_fin;
  logic [ADDR_W-1:0] size_s;
  logic [ADDR_W-1:0] step_s;
  logic [43:0]       mul_full;
  logic [31:0]       phase_nx;
  logic [31:0]       avg_nx;

  div_req_t div_req;
  div_rsp_t div_rsp;

  cscag_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  assign cols_eff = (cols_q == 32'd0) ? 32'd1 : cols_q;
  assign pes_eff  = (pes_q == 9'd0) ? 9'd1 : ((pes_q > 9'd256) ? 9'd256 : pes_q);
  assign in_acc   = in_valid_i && !in_stall_o;
  assign out_acc  = out_valid_o && !out_stall_i;
  assign seq_end  = (iter_q >= rtotal_q);
  assign div_fin  = (state_q == ST_DIV_WAIT) && div_rsp.done;

  always_comb begin
    div_req.start = (state_q == ST_DIV_START);
    case (job_q)
      JOB_AVG: begin
        div_req.dividend = {4'b0, nz_q};
        div_req.divisor  = cols_eff;
      end
      JOB_S0: begin
        div_req.dividend = {2'b0, cols_eff, 2'b0};
        div_req.divisor  = {23'b0, pes_eff};
      end
      JOB_S1: begin
        div_req.dividend = {2'b0, nz_q, 2'b0};
        div_req.divisor  = {23'b0, pes_eff};
      end
      JOB_S2: begin
        div_req.dividend = {1'b0, nz_q, 3'b0};
        div_req.divisor  = {23'b0, pes_eff};
      end
      JOB_S3: begin
        div_req.dividend = {1'b0, cols_eff, 3'b0};
        div_req.divisor  = {23'b0, pes_eff};
      end
      default: begin
        div_req.dividend = {7'b0, nz_q[31:3]};
        div_req.divisor  = {23'b0, pes_eff};
      end
    endcase
  end

  always_comb begin
    case (strm_q)
      STR_COLPTR: size_s = {4'b0, cols_eff, 2'b0};
      STR_ROWIDX: size_s = {4'b0, nz_q, 2'b0};
      default:    size_s = {3'b0, nz_q, 3'b0};
    endcase
    step_s   = (strm_q == STR_COLPTR) ? {cbc_q, 6'b0} : {2'b0, iter_q, 6'b0};
    mul_full = eng_q * stride_q[strm_q];
    avg_nx   = (div_rsp.quotient[31:0] == 32'd0) ? 32'd1 : div_rsp.quotient[31:0];
    phase_nx = (phase_q == 32'd0) ? (avg_q - 32'd1) : (phase_q - 32'd1);
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          if (restart_i)    state_d = ST_DIV_START;
          else if (seq_end) state_d = ST_OUT;
          else              state_d = ST_MUL;
        end
      end
      ST_DIV_START: state_d = ST_DIV_WAIT;
      ST_DIV_WAIT: begin
        if (div_rsp.done) state_d = (job_q == JOB_TOTAL) ? ST_IDLE : ST_DIV_START;
      end
      ST_MUL: state_d = ST_ADD;
      ST_ADD: state_d = ST_OUT;
      ST_OUT: begin
        if (out_acc) state_d = (done_q || last_q) ? ST_IDLE : ST_MUL;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    in_stall_o  = 1'b1;
    out_valid_o = 1'b0;
    case (state_q)
      ST_IDLE: in_stall_o  = 1'b0;
      ST_OUT:  out_valid_o = 1'b1;
      default: in_stall_o  = 1'b1;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      nz_q     <= 32'd0;
      cols_q   <= 32'd1;
      pes_q    <= 9'd1;
      iter_q   <= '0;
      eng_q    <= '0;
      cbc_q    <= '0;
      phase_q  <= '0;
      avg_q    <= 32'd1;
      rtotal_q <= '0;
      job_q    <= JOB_AVG;
      for (int k = 0; k < 4; k++) stride_q[k] <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        case (cfg_index_i)
          REG_NONZERO: nz_q   <= cfg_wdata_i;
          REG_COLUMNS: cols_q <= cfg_wdata_i;
          REG_ENGINES: pes_q  <= cfg_wdata_i[8:0];
          default:     pes_q  <= pes_q;
        endcase
      end
      if (in_acc && restart_i) begin
        job_q   <= JOB_AVG;
        iter_q  <= '0;
        eng_q   <= '0;
        cbc_q   <= '0;
        phase_q <= '0;
      end
      if (div_fin) begin
        case (job_q)
          JOB_AVG:   avg_q       <= avg_nx;
          JOB_S0:    stride_q[0] <= div_rsp.quotient;
          JOB_S1:    stride_q[1] <= div_rsp.quotient;
          JOB_S2:    stride_q[2] <= div_rsp.quotient;
          JOB_S3:    stride_q[3] <= div_rsp.quotient;
          default:   rtotal_q    <= div_rsp.quotient[29:0];
        endcase
        if (job_q != JOB_TOTAL) job_q <= div_job_e'(job_q + 3'd1);
      end
      if (state_q == ST_OUT && out_acc && last_q && !done_q) begin
        if ({1'b0, eng_q} + 9'd1 >= pes_eff) begin
          eng_q   <= '0;
          iter_q  <= iter_q + 30'd1;
          phase_q <= phase_nx;
          if (phase_nx == 32'd0) cbc_q <= cbc_q + 32'd1;
        end else begin
          eng_q <= eng_q + 8'd1;
        end
      end
    end
  end

  // request datapath
  always_ff @(posedge clk_i) begin
    if (in_acc && !restart_i) begin
      if (seq_end) begin
        addr_q <= '0;
        strm_q <= STR_COLPTR;
        last_q <= 1'b1;
        done_q <= 1'b1;
      end else begin
        done_q <= 1'b0;
        last_q <= 1'b0;
        if (phase_q == 32'd0) begin
          strm_q <= STR_COLPTR;
          base_q <= '0;
        end else begin
          strm_q <= STR_ROWIDX;
          base_q <= {4'b0, cols_eff, 2'b0};
        end
      end
    end
    if (state_q == ST_MUL) begin
      prod_q <= mul_full[ADDR_W-1:0];
      off_q  <= base_q + step_s;
    end
    if (state_q == ST_ADD) begin
      addr_q <= prod_q + off_q;
      last_q <= (strm_q == STR_VECTOR);
      base_q <= base_q + size_s;
    end
    if (state_q == ST_OUT && out_acc && !last_q) begin
      strm_q <= strm_q + 2'd1;
    end
  end

  assign address_o   = addr_q;
  assign stream_o    = strm_q;
  assign iteration_o = done_q ? 29'd0 : iter_q[28:0];
  assign engine_o    = done_q ? 8'd0 : eng_q;
  assign last_o      = last_q;
  assign done_res_o  = done_q;

  `CSCAG_ASSERT_IMP(a_done_is_last, clk_i, rst_ni, out_valid_o && done_res_o, last_o)
  `CSCAG_ASSERT_IMP(a_req_in_range, clk_i, rst_ni, out_valid_o && !done_res_o, iter_q < rtotal_q)
  `CSCAG_ASSERT_IMP(a_busy_on_out, clk_i, rst_ni, out_valid_o, in_stall_o)
  `CSCAG_ASSERT_NXT(a_div_ret, clk_i, rst_ni, div_fin, !in_stall_o || div_req.start)

endmodule

@@ tb/sv/testbench.sv @@
`timescale 1ns / 1ps

module testbench;
  import cscag_pkg::*;

  localparam int LIMIT_CYCLES  = 600000;
  localparam int SETTLE_CYCLES = 400;
  localparam int LONG_HOLD     = 300;
  localparam bit [63:0] BURST_BYTES  = 64;
  localparam bit [63:0] WIDE_BYTES   = 8;
  localparam bit [63:0] NARROW_BYTES = 4;

  typedef struct {
    logic [ADDR_W-1:0] address;
    stream_e           stream;
    logic [28:0]       iteration;
    logic [7:0]        engine;
    logic              last;
    logic              done;
  } request_t;

  class request_scoreboard;
    bit [31:0] nonzero_cnt;
    bit [31:0] column_cnt;
    bit [8:0]  engine_cnt;
    bit [29:0] iter_pos;
    bit [7:0]  engine_pos;
    bit [31:0] col_block;
    bit [31:0] countdown;
    bit [31:0] avg_len;
    bit [31:0] iter_total;
    bit [63:0] share [4];
    request_t  pending_q [$];
    int        mismatches;

    function new();
      nonzero_cnt = 0;
      column_cnt  = 1;
      engine_cnt  = 1;
      iter_pos    = 0;
      engine_pos  = 0;
      col_block   = 0;
      countdown   = 0;
      avg_len     = 1;
      iter_total  = 0;
      mismatches  = 0;
      foreach (share[k]) share[k] = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_NONZERO: nonzero_cnt = data;
        REG_COLUMNS: column_cnt = data;
        REG_ENGINES: engine_cnt = data[8:0];
        default: ;
      endcase
    endfunction

    function bit [63:0] live_engines();
      if (engine_cnt == 0) return 1;
      if (engine_cnt > 256) return 256;
      return 64'(engine_cnt);
    endfunction

    function void add_request(bit [63:0] addr, stream_e str, bit [29:0] it,
                              bit [7:0] en, bit last, bit done);
      request_t r;
      r.address   = addr[ADDR_W-1:0];
      r.stream    = str;
      r.iteration = it[28:0];
      r.engine    = en;
      r.last      = last;
      r.done      = done;
      pending_q.push_back(r);
    endfunction

    // one accepted word: rewind, done request, or requests of (iteration, engine)
    function void note_word(bit restart);
      bit [63:0] nz;
      bit [63:0] ncols;
      bit [63:0] pes;
      bit [63:0] pe;
      bit [63:0] base1;
      bit [63:0] base2;
      bit [63:0] base3;
      bit [63:0] step;
      bit [31:0] quot;
      nz    = 64'(nonzero_cnt);
      ncols = (column_cnt == 0) ? 64'd1 : 64'(column_cnt);
      pes   = live_engines();
      if (restart) begin
        quot       = 32'(nz / ncols);
        avg_len    = (quot == 0) ? 32'd1 : quot;
        share[0]   = (NARROW_BYTES * ncols) / pes;
        share[1]   = (NARROW_BYTES * nz) / pes;
        share[2]   = (WIDE_BYTES * nz) / pes;
        share[3]   = (WIDE_BYTES * ncols) / pes;
        iter_total = 32'((nz / 8) / pes);
        iter_pos   = 0;
        engine_pos = 0;
        col_block  = 0;
        countdown  = 0;
        return;
      end
      if (32'(iter_pos) >= iter_total) begin
        add_request(64'd0, STR_COLPTR, 30'd0, 8'd0, 1'b1, 1'b1);
        return;
      end
      pe    = 64'(engine_pos);
      base1 = NARROW_BYTES * ncols;
      base2 = base1 + NARROW_BYTES * nz;
      base3 = base2 + WIDE_BYTES * nz;
      step  = BURST_BYTES * 64'(iter_pos);
      if (countdown == 0)
        add_request(pe * share[0] + BURST_BYTES * 64'(col_block), STR_COLPTR,
                    iter_pos, engine_pos, 1'b0, 1'b0);
      add_request(base1 + pe * share[1] + step, STR_ROWIDX, iter_pos, engine_pos, 1'b0, 1'b0);
      add_request(base2 + pe * share[2] + step, STR_VALUE, iter_pos, engine_pos, 1'b0, 1'b0);
      add_request(base3 + pe * share[3] + step, STR_VECTOR, iter_pos, engine_pos, 1'b1, 1'b0);
      if (64'(engine_pos) + 1 >= pes) begin
        engine_pos = 0;
        iter_pos   = iter_pos + 1;
        countdown  = (countdown == 0) ? avg_len - 1 : countdown - 1;
        if (countdown == 0) col_block = col_block + 1;
      end else begin
        engine_pos = engine_pos + 1;
      end
    endfunction

    function void check_result(request_t got);
      request_t want;
      if (pending_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected request: addr %h stream %0d iter %0d engine %0d last %0b done %0b",
                   got.address, got.stream, got.iteration, got.engine, got.last, got.done);
        return;
      end
      want = pending_q.pop_front();
      if (got.address !== want.address || got.stream !== want.stream ||
          got.iteration !== want.iteration || got.engine !== want.engine ||
          got.last !== want.last || got.done !== want.done) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("request mismatch at %0t", $realtime);
          $display("  expected addr %h stream %0d iter %0d engine %0d last %0b done %0b",
                   want.address, want.stream, want.iteration, want.engine, want.last,
                   want.done);
          $display("  actual   addr %h stream %0d iter %0d engine %0d last %0b done %0b",
                   got.address, got.stream, got.iteration, got.engine, got.last, got.done);
        end
      end
    endfunction
  endclass

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_index_i;
  logic [CFG_DATA_W-1:0] cfg_wdata_i;
  logic                  in_valid_i;
  logic                  in_stall_o;
  logic                  restart_i;
  logic                  out_valid_o;
  logic                  out_stall_i;
  logic [ADDR_W-1:0]     address_o;
  logic [1:0]            stream_o;
  logic [28:0]           iteration_o;
  logic [7:0]            engine_o;
  logic                  last_o;
  logic                  done_res_o;

  request_scoreboard sb;
  request_t          seen;
  bit                calm = 1'b0;
  bit                long_hold = 1'b0;
  int                cycles = 0;

  csc_spmv_request_address_generator u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .restart_i   (restart_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .address_o   (address_o),
    .stream_o    (stream_o),
    .iteration_o (iteration_o),
    .engine_o    (engine_o),
    .last_o      (last_o),
    .done_res_o  (done_res_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT_CYCLES) begin
      $display("simulation failed");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        seen.address   = address_o;
        seen.stream    = stream_e'(stream_o);
        seen.iteration = iteration_o;
        seen.engine    = engine_o;
        seen.last      = last_o;
        seen.done      = done_res_o;
        sb.check_result(seen);
      end
      if (in_valid_i && !in_stall_o) sb.note_word(restart_i);
      if (cfg_we_i) sb.write_reg(cfg_index_i, cfg_wdata_i);
    end
  end

  // output backpressure: random bursts, or one long hold on request
  initial begin
    int burst;
    burst = 0;
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (long_hold) begin
        long_hold = 1'b0;
        burst = LONG_HOLD;
      end else if (burst == 0 && !calm && $urandom_range(0, 6) == 0) begin
        burst = $urandom_range(1, 10);
      end
      if (burst > 0) begin
        out_stall_i <= 1'b1;
        burst--;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  task automatic send_word(input bit restart);
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 10)) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    restart_i  <= restart;
    do @(posedge clk_i); while (in_stall_o);
    @(negedge clk_i);
  endtask

  task automatic write_config(input logic [31:0] nz, input logic [31:0] cols,
                              input logic [31:0] eng);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= REG_NONZERO;
    cfg_wdata_i <= nz;
    @(negedge clk_i);
    cfg_index_i <= REG_COLUMNS;
    cfg_wdata_i <= cols;
    @(negedge clk_i);
    cfg_index_i <= REG_ENGINES;
    cfg_wdata_i <= eng;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // drain all requests, then give a restart time to finish its divides
  task automatic settle();
    in_valid_i <= 1'b0;
    while (sb.pending_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic run_phase(input logic [31:0] nz, input logic [31:0] cols,
                           input logic [31:0] eng, input bit rewind, input int words,
                           input int restart_pct, input bit squeeze);
    settle();
    write_config(nz, cols, eng);
    if (rewind) send_word(1'b1);
    if (squeeze) long_hold = 1'b1;
    repeat (words) send_word($urandom_range(0, 99) < restart_pct);
  endtask

  initial begin
    logic [31:0] nz;
    logic [31:0] cols;
    logic [31:0] eng;
    sb = new();
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    restart_i   = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_index_i = REG_NONZERO;
    cfg_wdata_i = '0;
    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;

    // reset state: nothing to run, done at once
    repeat (2) send_word(1'b0);
    run_phase(64, 4, 2, 1'b1, 9, 0, 1'b0);
    // fewer nonzeros than columns: average length divides to zero and is held at one
    run_phase(24, 100, 1, 1'b1, 4, 0, 1'b0);
    run_phase(32'hFFFF_FFFF, 32'hFFFF_FFFF, 256, 1'b1, 3, 0, 1'b0);
    run_phase(32'hFFFF_FFFF, 1, 1, 1'b1, 2, 0, 1'b0);
    // zero columns, engine count zero and above range
    run_phase(40, 0, 0, 1'b1, 2, 0, 1'b0);
    run_phase(0, 7, 300, 1'b1, 2, 0, 1'b0);

    for (int p = 0; p < 7; p++) begin
      eng  = ($urandom_range(0, 5) == 0) ? $urandom_range(1, 256) : $urandom_range(1, 4);
      nz   = ($urandom_range(0, 7) == 0) ? $urandom() : $urandom_range(0, 8 * eng * 12);
      cols = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 32'hFFFF_FFFF)
                                         : $urandom_range(1, 48);
      if (p == 6) calm = 1'b1;
      run_phase(nz, cols, eng, $urandom_range(0, 9) != 0, 19, 4, p == 2);
    end

    settle();
    if (sb.mismatches == 0 && sb.pending_q.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

@@ csc_spmv_request_address_generator.f @@
+incdir+rtl
rtl/cscag_pkg.sv
rtl/cscag_div.sv
rtl/csc_spmv_request_address_generator.sv
tb/sv/testbench.sv
